// ----- hdl/edsh_pkg.sv -----
// Shared types, constants and decode functions for the end-distance
// substitution histogram. No dependencies; the top level and edsh_decode import it.
package edsh_pkg;

	localparam int CELLS = 16;
	localparam int CNT_W = 40;
	localparam int WEIGHT_W = 12;

	localparam logic [7:0] CHAR_S = 8'h53;
	localparam logic [7:0] CHAR_I = 8'h49;
	localparam logic [7:0] CHAR_M = 8'h4D;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_THREE = 8'h33;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

	// Request kinds carried in tuser.
	localparam logic REQ_ACCUM = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Base code: 0..3 for A C G T, bit 2 set means unknown.
	typedef logic [2:0] base_code_t;
	localparam base_code_t CODE_A = 3'd0;
	localparam base_code_t CODE_C = 3'd1;
	localparam base_code_t CODE_G = 3'd2;
	localparam base_code_t CODE_T = 3'd3;
	localparam base_code_t CODE_N = 3'd4;

	// Packed read base codes.
	localparam logic [3:0] PACK_A = 4'h1;
	localparam logic [3:0] PACK_C = 4'h2;
	localparam logic [3:0] PACK_G = 4'h4;
	localparam logic [3:0] PACK_T = 4'h8;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// Where one accumulate item lands in the two tables.
	typedef struct packed {
		logic       ok5;
		logic       ok3;
		logic [8:0] d5;
		logic [8:0] d3;
		logic [3:0] cell_idx;
	} edsh_plan_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
			return c - 8'd32;
		return c;
	endfunction

	function automatic base_code_t symbol_code(input logic [7:0] c);
		if (c <= 8'd3)
			return base_code_t'(c);
		if (c >= CHAR_ZERO && c <= CHAR_THREE)
			return base_code_t'(c - CHAR_ZERO);
		case (c)
			CHAR_A: return CODE_A;
			CHAR_C: return CODE_C;
			CHAR_G: return CODE_G;
			CHAR_T: return CODE_T;
			default: return CODE_N;
		endcase
	endfunction

	function automatic base_code_t packed_code(input logic [3:0] p);
		case (p)
			PACK_A: return CODE_A;
			PACK_C: return CODE_C;
			PACK_G: return CODE_G;
			PACK_T: return CODE_T;
			default: return CODE_N;
		endcase
	endfunction

endpackage

// ----- hdl/end_distance_substitution_histogram.sv -----
// Top level of the end-distance substitution histogram: control, the two
// counter tables and the result register. Depends on edsh_pkg, edsh_decode
// and edsh_count_ram.

// The block keeps two tables of 40-bit saturating counters (unsigned Q32.8),
// one indexed by distance from the 5' end of a read and one by distance from
// the 3' end, each row holding 16 cells (reference code times 4 plus read
// code, A=0 C=1 G=2 T=3). An accumulate item (tuser 0) that passes the filters
// of edsh_decode adds its weight to the matching cell of every table whose
// distance row exists and returns was_counted; a read item (tuser 1) returns
// one counter. Every item returns exactly one result item. After reset the
// block sweeps both tables to zero, one entry per cycle; no item is accepted
// during that sweep, while writes to min_quality are taken at any time. For
// each item, in the cycle it is accepted both tables are read into the
// registered memory outputs; in the update state the updated counters are
// written back and the result is loaded into the output register, once that
// register is free. This read-modify-write means a new item is accepted only
// after the previous one has been written back, though it can be accepted
// while the previous result still waits in the output register; the
// write-back of that new item waits only until the output register is free.
module end_distance_substitution_histogram #(
	parameter int DISTANCE_DEPTH = 32,
	parameter int MAX_READ_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item.
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] ref_symbol, [11:8] read_base_code, [19:12] base_quality,
	// [27:20] base_offset, [36:28] read_length, [37] reverse_strand,
	// [49:38] weight, [50] sel_end, [55:51] sel_distance, [59:56] sel_cell
	input  logic [63:0] s_tdata,
	// [0] req_type
	input  logic        s_tuser,
	// Result item.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [39:0] counter_value, [40] was_counted
	output logic [47:0] m_tdata,
	// Configuration: min_quality.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import edsh_pkg::*;

	localparam int WORDS = DISTANCE_DEPTH * CELLS;
	localparam int ADDR_W = $clog2(WORDS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Unpacked input fields.
	logic                req_type;
	logic [7:0]          ref_symbol;
	logic [3:0]          read_base_code;
	logic [7:0]          base_quality;
	logic [7:0]          base_offset;
	logic [8:0]          read_length;
	logic                reverse_strand;
	logic [WEIGHT_W-1:0] weight;
	logic                sel_end;
	logic [4:0]          sel_distance;
	logic [3:0]          sel_cell;

	assign req_type       = s_tuser;
	assign ref_symbol     = s_tdata[7:0];
	assign read_base_code = s_tdata[11:8];
	assign base_quality   = s_tdata[19:12];
	assign base_offset    = s_tdata[27:20];
	assign read_length    = s_tdata[36:28];
	assign reverse_strand = s_tdata[37];
	assign weight         = s_tdata[49:38];
	assign sel_end        = s_tdata[50];
	assign sel_distance   = s_tdata[55:51];
	assign sel_cell       = s_tdata[59:56];

	state_t              state_q;
	state_t              state_d;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [7:0]          min_quality_q;

	edsh_plan_t          plan;
	logic                accept;
	logic                finish;

	// Item held between the read and the write-back.
	logic                req_s1;
	logic                sel_end_s1;
	logic                sel_ok_s1;
	logic                ok5_s1;
	logic                ok3_s1;
	logic [ADDR_W-1:0]   addr5_s1;
	logic [ADDR_W-1:0]   addr3_s1;
	logic [WEIGHT_W-1:0] weight_s1;

	// Memory ports.
	logic [ADDR_W-1:0]   rd_addr5;
	logic [ADDR_W-1:0]   rd_addr3;
	logic [CNT_W-1:0]    rd_data5;
	logic [CNT_W-1:0]    rd_data3;
	logic                wr_en5;
	logic                wr_en3;
	logic [ADDR_W-1:0]   wr_addr5;
	logic [ADDR_W-1:0]   wr_addr3;
	logic [CNT_W-1:0]    wr_data5;
	logic [CNT_W-1:0]    wr_data3;
	logic [CNT_W:0]      sum5;
	logic [CNT_W:0]      sum3;

	// Output register.
	logic                m_valid_q;
	logic [CNT_W-1:0]    counter_q;
	logic                counted_q;
	logic [CNT_W-1:0]    counter_d;
	logic                counted_d;

	edsh_decode #(
		.DISTANCE_DEPTH(DISTANCE_DEPTH),
		.MAX_READ_LEN(MAX_READ_LEN)
	) u_decode (
		.ref_symbol(ref_symbol),
		.read_base_code(read_base_code),
		.base_quality(base_quality),
		.base_offset(base_offset),
		.read_length(read_length),
		.reverse_strand(reverse_strand),
		.min_quality(min_quality_q),
		.plan(plan)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_quality_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			min_quality_q <= cfg_data;
		end
	end

	// A read item reads both tables at the selected entry; an accumulate item
	// reads each table at its own distance row.
	always_comb begin
		if (req_type == REQ_READ) begin
			rd_addr5 = ADDR_W'(32'(sel_distance) * CELLS + 32'(sel_cell));
			rd_addr3 = rd_addr5;
		end else begin
			rd_addr5 = ADDR_W'(32'(plan.d5) * CELLS + 32'(plan.cell_idx));
			rd_addr3 = ADDR_W'(32'(plan.d3) * CELLS + 32'(plan.cell_idx));
		end
	end

	// Control: clear sweep, wait for an item, write back.
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				finish = !m_valid_q || m_tready;
				if (finish)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			sel_end_s1 <= sel_end;
			sel_ok_s1 <= 32'(sel_distance) < 32'(DISTANCE_DEPTH);
			ok5_s1 <= plan.ok5;
			ok3_s1 <= plan.ok3;
			addr5_s1 <= rd_addr5;
			addr3_s1 <= rd_addr3;
			weight_s1 <= weight;
		end
	end

	// Saturating weight add to each counter read, or zeros while clearing.
	always_comb begin
		sum5 = {1'b0, rd_data5} + (CNT_W + 1)'(weight_s1);
		sum3 = {1'b0, rd_data3} + (CNT_W + 1)'(weight_s1);
		if (state_q == ST_CLEAR) begin
			wr_en5 = 1'b1;
			wr_en3 = 1'b1;
			wr_addr5 = clr_addr_q;
			wr_addr3 = clr_addr_q;
			wr_data5 = '0;
			wr_data3 = '0;
		end else begin
			wr_en5 = finish && (req_s1 == REQ_ACCUM) && ok5_s1;
			wr_en3 = finish && (req_s1 == REQ_ACCUM) && ok3_s1;
			wr_addr5 = addr5_s1;
			wr_addr3 = addr3_s1;
			wr_data5 = sum5[CNT_W] ? CNT_MAX : sum5[CNT_W-1:0];
			wr_data3 = sum3[CNT_W] ? CNT_MAX : sum3[CNT_W-1:0];
		end
	end

	edsh_count_ram #(
		.WORDS(WORDS),
		.DATA_W(CNT_W)
	) u_five_prime (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(rd_addr5),
		.rd_data(rd_data5),
		.wr_en(wr_en5),
		.wr_addr(wr_addr5),
		.wr_data(wr_data5)
	);

	edsh_count_ram #(
		.WORDS(WORDS),
		.DATA_W(CNT_W)
	) u_three_prime (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(rd_addr3),
		.rd_data(rd_data3),
		.wr_en(wr_en3),
		.wr_addr(wr_addr3),
		.wr_data(wr_data3)
	);

	// Result of the item in write-back.
	always_comb begin
		if (req_s1 == REQ_READ) begin
			counter_d = sel_ok_s1 ? (sel_end_s1 ? rd_data3 : rd_data5) : '0;
			counted_d = 1'b0;
		end else begin
			counter_d = '0;
			counted_d = ok5_s1 || ok3_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			counter_q <= counter_d;
			counted_q <= counted_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'd0, counted_q, counter_q};

endmodule

// ----- hdl/edsh_count_ram.sv -----
// One counter table: a simple dual-port synchronous memory with a registered
// read. Depends on nothing but its parameters.
module edsh_count_ram #(
	parameter int WORDS = 512,
	parameter int DATA_W = 40
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(WORDS)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(WORDS)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [WORDS];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/edsh_decode.sv -----
// Turns one accumulate item into the cell and the two end distances it adds
// to, with the filters for clipping, quality, unknown bases and range.
// Depends on edsh_pkg.
module edsh_decode #(
	parameter int DISTANCE_DEPTH = 32,
	parameter int MAX_READ_LEN = 256
) (
	input  logic [7:0]              ref_symbol,
	input  logic [3:0]              read_base_code,
	input  logic [7:0]              base_quality,
	input  logic [7:0]              base_offset,
	input  logic [8:0]              read_length,
	input  logic                    reverse_strand,
	input  logic [7:0]              min_quality,
	output edsh_pkg::edsh_plan_t    plan
);
	import edsh_pkg::*;

	logic [7:0] sym;
	base_code_t read_c;
	base_code_t ref_c;
	logic       usable;
	logic       far_ok;
	logic [8:0] far;
	logic       ok5_raw;
	logic       ok3_raw;
	logic [8:0] d5;
	logic [8:0] d3;
	logic [1:0] ref_b;
	logic [1:0] read_b;

	always_comb begin
		sym = fold_upper(ref_symbol);
		read_c = packed_code(read_base_code);
		ref_c = (sym == CHAR_M) ? read_c : symbol_code(sym);
		usable = !(sym == CHAR_S || sym == CHAR_I)
			&& !(base_quality < min_quality)
			&& !(32'(read_length) > 32'(MAX_READ_LEN))
			&& !ref_c[2] && !read_c[2];

		// Distance from the far end exists only for an offset inside the read.
		far_ok = {1'b0, base_offset} < read_length;
		far = far_ok ? (read_length - 9'd1 - {1'b0, base_offset}) : 9'd0;

		if (reverse_strand) begin
			ref_b = ~ref_c[1:0];
			read_b = ~read_c[1:0];
			ok5_raw = far_ok;
			d5 = far;
			ok3_raw = 1'b1;
			d3 = {1'b0, base_offset};
		end else begin
			ref_b = ref_c[1:0];
			read_b = read_c[1:0];
			ok5_raw = 1'b1;
			d5 = {1'b0, base_offset};
			ok3_raw = far_ok;
			d3 = far;
		end

		plan.ok5 = usable && ok5_raw && (32'(d5) < 32'(DISTANCE_DEPTH));
		plan.ok3 = usable && ok3_raw && (32'(d3) < 32'(DISTANCE_DEPTH));
		plan.d5 = d5;
		plan.d3 = d3;
		plan.cell_idx = {ref_b, read_b};
	end

endmodule
